>>> hdl/xeu_pkg.sv
package xeu_pkg;

   // entity numbering, also the priority order when several candidates are live
   localparam int NumEnt = 6;
   localparam logic [2:0] ENT_LT   = 3'd0;
   localparam logic [2:0] ENT_GT   = 3'd1;
   localparam logic [2:0] ENT_AMP  = 3'd2;
   localparam logic [2:0] ENT_APOS = 3'd3;
   localparam logic [2:0] ENT_QUOT = 3'd4;
   localparam logic [2:0] ENT_HEXA = 3'd5;

   localparam logic [5:0] ALL_LIVE = 6'b11_1111;
   localparam logic [7:0] CHAR_AMP = "&";

   // entity text, padded with zero
   localparam logic [7:0] ENT_TEXT [0:NumEnt-1][0:5] = '{
      '{"&", "l", "t", ";", 8'h00, 8'h00},
      '{"&", "g", "t", ";", 8'h00, 8'h00},
      '{"&", "a", "m", "p", ";",   8'h00},
      '{"&", "a", "p", "o", "s",   ";"},
      '{"&", "q", "u", "o", "t",   ";"},
      '{"&", "#", "x", "A", ";",   8'h00}
   };
   localparam logic [2:0] ENT_LEN [0:NumEnt-1] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd5};

   // replacement text, second byte only used for the line break
   localparam logic [7:0] ENT_REPL [0:NumEnt-1][0:1] = '{
      '{"<",   8'h00},
      '{">",   8'h00},
      '{"&",   8'h00},
      '{"'",   8'h00},
      '{8'h22, 8'h00},
      '{8'h0d, 8'h0a}
   };
   localparam logic [1:0] ENT_REPL_LEN [0:NumEnt-1] = '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2};

   // one decoded item's worth of work for the back end
   typedef struct packed {
      logic       rep;       // emit the replacement of rep_ent
      logic [2:0] rep_ent;
      logic [2:0] pre_ent;   // emit first pre_len bytes of this entity's text
      logic [2:0] pre_len;
      logic       has_lit;   // then one literal byte
      logic [7:0] lit;
      logic       eot;       // string ends with this item
   } cmd_type;

   function automatic logic [7:0] ent_char(input logic [2:0] ent, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (ent < 3'(NumEnt) && pos < 3'd6) begin
         ch = ENT_TEXT[ent][pos];
      end
      return ch;
   endfunction

   function automatic logic [2:0] ent_len(input logic [2:0] ent);
      logic [2:0] len;
      len = 3'd0;
      if (ent < 3'(NumEnt)) begin
         len = ENT_LEN[ent];
      end
      return len;
   endfunction

   function automatic logic [7:0] repl_char(input logic [2:0] ent, input logic pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (ent < 3'(NumEnt)) begin
         ch = ENT_REPL[ent][pos];
      end
      return ch;
   endfunction

   function automatic logic [1:0] repl_len(input logic [2:0] ent);
      logic [1:0] len;
      len = 2'd0;
      if (ent < 3'(NumEnt)) begin
         len = ENT_REPL_LEN[ent];
      end
      return len;
   endfunction

endpackage

>>> hdl/xeu_if.sv
interface xeu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface xeu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       last_of_text;

   modport source (output valid, output out_byte, output last_of_run, output last_of_text,
                   input ready);
   modport sink   (input valid, input out_byte, input last_of_run, input last_of_text,
                   output ready);
endinterface

>>> hdl/xeu_front.sv
module xeu_front (
   input  logic             clock,
   input  logic             reset,
   xeu_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             q_push,
   output xeu_pkg::cmd_type q_cmd
);

   logic [2:0] held_ff, held_in;
   logic [5:0] live_ff, live_in;
   logic [5:0] next_live;
   logic       done_hit;
   logic [2:0] done_ent;
   logic [2:0] held_inc;
   logic       fresh;
   logic       accept;
   logic       push_cmd;
   xeu_pkg::cmd_type cmd;

   // lowest live candidate stands for the held bytes
   function automatic logic [2:0] first_live(input logic [5:0] mask);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = xeu_pkg::NumEnt - 1; i >= 0; i--) begin
         if (mask[i]) idx = 3'(i);
      end
      return idx;
   endfunction

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign held_inc       = held_ff + 3'd1;

   // candidates that survive this byte, and a completed entity if any
   always_comb begin
      next_live = '0;
      done_hit  = 1'b0;
      done_ent  = 3'd0;
      for (int i = 0; i < xeu_pkg::NumEnt; i++) begin
         if (live_ff[i] && xeu_pkg::ent_len(3'(i)) > held_ff &&
             xeu_pkg::ent_char(3'(i), held_ff) == req_chan.in_byte) begin
            next_live[i] = 1'b1;
            if (xeu_pkg::ent_len(3'(i)) == held_inc) begin
               done_hit = 1'b1;
               done_ent = 3'(i);
            end
         end
      end
   end

   // classify the item into a command for the back end
   always_comb begin
      cmd      = '0;
      cmd.eot  = req_chan.end_of_text;
      push_cmd = 1'b0;
      held_in  = held_ff;
      live_in  = live_ff;
      fresh    = 1'b1;
      if (held_ff != 3'd0) begin
         if (next_live != '0) begin
            fresh = 1'b0;
            if (done_hit) begin
               cmd.rep     = 1'b1;
               cmd.rep_ent = done_ent;
               push_cmd    = 1'b1;
               held_in     = 3'd0;
               live_in     = '0;
            end else if (req_chan.end_of_text) begin
               // string ends inside a prefix: flush it
               cmd.pre_ent = first_live(next_live);
               cmd.pre_len = held_inc;
               push_cmd    = 1'b1;
               held_in     = 3'd0;
               live_in     = '0;
            end else begin
               held_in = held_inc;
               live_in = next_live;
            end
         end else begin
            // mismatch: held bytes go out unchanged
            cmd.pre_ent = first_live(live_ff);
            cmd.pre_len = held_ff;
            push_cmd    = 1'b1;
            held_in     = 3'd0;
            live_in     = '0;
         end
      end
      if (fresh) begin
         if (req_chan.in_byte == xeu_pkg::CHAR_AMP && !req_chan.end_of_text) begin
            held_in = 3'd1;
            live_in = xeu_pkg::ALL_LIVE;
         end else begin
            cmd.has_lit = 1'b1;
            cmd.lit     = req_chan.in_byte;
            push_cmd    = 1'b1;
         end
      end
   end

   assign q_push = accept && push_cmd;
   assign q_cmd  = cmd;

   // match state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 3'd0;
         live_ff <= '0;
      end else if (accept) begin
         held_ff <= held_in;
         live_ff <= live_in;
      end
   end

endmodule

>>> hdl/xeu_fifo.sv
module xeu_fifo #(
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xeu_pkg::cmd_type push_cmd,
   input  logic             pop,
   output xeu_pkg::cmd_type head_cmd,
   output logic             empty,
   output logic             full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   xeu_pkg::cmd_type slot_ff [0:Depth-1];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;
   logic             do_push, do_pop;

   assign empty    = (count_ff == CntW'(0));
   assign full     = (count_ff == CntW'(Depth));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> hdl/xeu_back.sv
module xeu_back (
   input  logic             clock,
   input  logic             reset,
   input  xeu_pkg::cmd_type head_cmd,
   input  logic             q_empty,
   output logic             q_pop,
   xeu_rsp_if.source        rsp_chan
);

   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       is_last;
   logic       fire;

   // bytes this command expands to
   always_comb begin
      if (head_cmd.rep) begin
         total = {1'b0, xeu_pkg::repl_len(head_cmd.rep_ent)};
      end else begin
         total = head_cmd.pre_len + {2'b00, head_cmd.has_lit};
      end
   end

   assign is_last = (idx_ff == total - 3'd1);
   assign fire    = rsp_chan.valid && rsp_chan.ready;

   // select the byte at the current position
   always_comb begin
      if (head_cmd.rep) begin
         rsp_chan.out_byte = xeu_pkg::repl_char(head_cmd.rep_ent, idx_ff[0]);
      end else if (idx_ff < head_cmd.pre_len) begin
         rsp_chan.out_byte = xeu_pkg::ent_char(head_cmd.pre_ent, idx_ff);
      end else begin
         rsp_chan.out_byte = head_cmd.lit;
      end
   end

   assign rsp_chan.valid        = !q_empty;
   assign rsp_chan.last_of_run  = is_last;
   assign rsp_chan.last_of_text = is_last && head_cmd.eot;
   assign q_pop                 = fire && is_last;
   assign idx_in                = q_pop ? 3'd0 : idx_ff + 3'd1;

   // position within the current command
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else if (fire) begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> hdl/xml_entity_unescape.sv
// channel | dir | modport          | payload
// --------+-----+------------------+-------------------------------------------
// req     | in  | xeu_req_if.sink  | in_byte[7:0], end_of_text
// rsp     | out | xeu_rsp_if.source| out_byte[7:0], last_of_run, last_of_text
//
// one item per cycle is taken while the command queue has room; an item that
// produces n bytes (0 to 6) occupies the output serializer until all n are sent.
// first result byte is offered from the command queue, after any commands ahead of it.
// reset is synchronous and clears the match state and empties the queue.
// input stalls only when QueueDepth commands wait behind a slow or stalled output.
module xml_entity_unescape #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   xeu_req_if.sink    req_chan,
   xeu_rsp_if.source  rsp_chan
);

   xeu_pkg::cmd_type push_cmd, head_cmd;
   logic             push, pop, q_empty, q_full;

   // match front end
   xeu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (push),
      .q_cmd    (push_cmd)
   );

   // command queue
   xeu_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // output serializer
   xeu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_empty  (q_empty),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int HalfPeriod    = 6;
   localparam int ResetCycles   = 12;
   localparam int RandomItems   = 160;
   localparam int HoldOffCycles = 80;
   localparam int DrainCycles   = 20;
   localparam int CycleLimit    = 300000;
   localparam int DirectedCount = 42;

   // one decoded byte as it leaves the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       last_of_text;
   } decoded_type;

   // one input item, with its decoded text written out where it is obvious
   typedef struct {
      logic [7:0] in_byte;
      logic       end_of_text;
      bit         known;
      string      known_text;
   } stim_type;

   // entity spellings and replacements, rows in the order lt gt amp apos quot #xA
   localparam logic [7:0] ENTITY_CHARS [0:xeu_pkg::NumEnt-1][0:5] = '{
      '{"&", "l", "t", ";", 8'h00, 8'h00},
      '{"&", "g", "t", ";", 8'h00, 8'h00},
      '{"&", "a", "m", "p", ";", 8'h00},
      '{"&", "a", "p", "o", "s", ";"},
      '{"&", "q", "u", "o", "t", ";"},
      '{"&", "#", "x", "A", ";", 8'h00}
   };
   localparam int ENTITY_SIZE [0:xeu_pkg::NumEnt-1] = '{4, 4, 5, 6, 6, 5};
   localparam logic [7:0] SUBST_CHARS [0:xeu_pkg::NumEnt-1][0:1] = '{
      '{"<", 8'h00}, '{">", 8'h00}, '{"&", 8'h00},
      '{"'", 8'h00}, '{8'h22, 8'h00}, '{8'h0d, 8'h0a}
   };
   localparam int SUBST_SIZE [0:xeu_pkg::NumEnt-1] = '{1, 1, 1, 1, 1, 2};

   // directed items: extremes, all six entities, mismatch, end of string
   stim_type directed_rows [DirectedCount] = '{
      '{8'h00, 1'b0, 1'b0, ""},
      '{8'hff, 1'b1, 1'b1, "\377"},
      '{"&", 1'b0, 1'b1, ""}, '{"l", 1'b0, 1'b1, ""},
      '{"t", 1'b0, 1'b1, ""}, '{";", 1'b0, 1'b1, "<"},
      '{"&", 1'b0, 1'b1, ""}, '{"g", 1'b0, 1'b1, ""},
      '{"t", 1'b0, 1'b1, ""}, '{";", 1'b1, 1'b1, ">"},
      '{"&", 1'b0, 1'b1, ""}, '{"a", 1'b0, 1'b1, ""}, '{"m", 1'b0, 1'b1, ""},
      '{"p", 1'b0, 1'b1, ""}, '{";", 1'b0, 1'b1, "&"},
      '{"&", 1'b0, 1'b1, ""}, '{"a", 1'b0, 1'b1, ""}, '{"p", 1'b0, 1'b1, ""},
      '{"o", 1'b0, 1'b1, ""}, '{"s", 1'b0, 1'b1, ""}, '{";", 1'b0, 1'b1, "'"},
      '{"&", 1'b0, 1'b1, ""}, '{"q", 1'b0, 1'b1, ""}, '{"u", 1'b0, 1'b1, ""},
      '{"o", 1'b0, 1'b1, ""}, '{"t", 1'b0, 1'b1, ""}, '{";", 1'b0, 1'b1, "\""},
      '{"&", 1'b0, 1'b1, ""}, '{"#", 1'b0, 1'b1, ""}, '{"x", 1'b0, 1'b1, ""},
      '{"A", 1'b0, 1'b1, ""}, '{";", 1'b0, 1'b1, "\015\012"},
      // five held bytes then a zero byte: six results in one step
      '{"&", 1'b0, 1'b1, ""}, '{"q", 1'b0, 1'b1, ""}, '{"u", 1'b0, 1'b1, ""},
      '{"o", 1'b0, 1'b1, ""}, '{"t", 1'b0, 1'b1, ""}, '{8'h00, 1'b0, 1'b0, ""},
      // an ampersand at end of string goes out as is, a prefix cut by end of string flushes
      '{"&", 1'b0, 1'b1, ""}, '{"&", 1'b1, 1'b1, "&&"},
      '{"&", 1'b0, 1'b1, ""}, '{"a", 1'b1, 1'b1, "&a"}
   };

   logic clock;
   logic reset;

   xeu_req_if req_if ();
   xeu_rsp_if rsp_if ();

   xml_entity_unescape u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   stim_type    stimulus [$];
   decoded_type pending_results [$];
   decoded_type step_bytes [$];
   logic [2:0]  held_len;
   logic [5:0]  live_set;
   int          taken_count;
   int          error_count;
   bit          hold_off_req;
   bit          quiet_phase;

   initial clock = 1'b0;
   always #HalfPeriod clock = ~clock;

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      step_bytes.push_back('{b, 1'b0, 1'b0});
   endtask

   // emit the held prefix, spelled as the lowest live entity
   task automatic flush_prefix();
      int src;
      src = xeu_pkg::ENT_LT;
      for (int i = xeu_pkg::NumEnt - 1; i >= 0; i--) begin
         if (live_set[i]) src = i;
      end
      for (int i = 0; i < held_len; i++) push_byte(ENTITY_CHARS[src][i]);
      held_len = '0;
      live_set = '0;
   endtask

   // decoder predictor: one input byte in, decoded bytes into step_bytes
   task automatic decode_step(input logic [7:0] b, input logic eot);
      logic [5:0] next_set;
      int         done_ent;
      logic       fresh;
      step_bytes.delete();
      fresh = 1'b1;
      // extend the held prefix
      if (held_len != 0) begin
         next_set = '0;
         for (int i = 0; i < xeu_pkg::NumEnt; i++) begin
            if (live_set[i] && ENTITY_SIZE[i] > held_len && ENTITY_CHARS[i][held_len] == b)
               next_set[i] = 1'b1;
         end
         if (next_set != '0) begin
            fresh = 1'b0;
            done_ent = -1;
            for (int i = 0; i < xeu_pkg::NumEnt; i++) begin
               if (next_set[i] && ENTITY_SIZE[i] == held_len + 1) done_ent = i;
            end
            if (done_ent >= 0) begin
               for (int j = 0; j < SUBST_SIZE[done_ent]; j++)
                  push_byte(SUBST_CHARS[done_ent][j]);
               held_len = '0;
               live_set = '0;
            end else begin
               held_len = held_len + 3'd1;
               live_set = next_set;
            end
         end else begin
            flush_prefix();
         end
      end
      // byte not consumed by a match
      if (fresh) begin
         if (b == xeu_pkg::CHAR_AMP) begin
            held_len = 3'd1;
            live_set = xeu_pkg::ALL_LIVE;
         end else begin
            push_byte(b);
         end
      end
      // end of string
      if (eot) begin
         if (held_len != 0) flush_prefix();
         if (step_bytes.size() > 0) step_bytes[$].last_of_text = 1'b1;
      end
      if (step_bytes.size() > 0) step_bytes[$].last_of_run = 1'b1;
   endtask

   task automatic add_item(input logic [7:0] b);
      stimulus.push_back('{b, ($urandom_range(0, 11) == 0), 1'b0, ""});
   endtask

   // random text: mostly entities, some cut short, plus plain bytes and junk
   task automatic build_random();
      string alphabet;
      int    kind;
      int    ent;
      int    cut;
      alphabet = "lgtampoqusx#A;&";
      while (stimulus.size() < DirectedCount + RandomItems) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            ent = $urandom_range(xeu_pkg::ENT_LT, xeu_pkg::ENT_HEXA);
            cut = ENTITY_SIZE[ent];
            if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, ENTITY_SIZE[ent] - 1);
            for (int k = 0; k < cut; k++) add_item(ENTITY_CHARS[ent][k]);
            if (cut < ENTITY_SIZE[ent]) add_item(8'($urandom_range(0, 255)));
         end else if (kind < 9) begin
            repeat ($urandom_range(1, 4)) add_item(8'($urandom_range(0, 255)));
         end else begin
            add_item(xeu_pkg::CHAR_AMP);
            repeat ($urandom_range(1, 5))
               add_item(alphabet[$urandom_range(0, alphabet.len() - 1)]);
         end
      end
   endtask

   // check results, then predict for the item taken at this edge
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      stim_type    item;
      int          n;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.out_byte, rsp_if.last_of_run, rsp_if.last_of_text};
            if (pending_results.size() == 0) begin
               $error("unexpected item: out_byte 8'h%02h", got.out_byte);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected 8'h%02h, got 8'h%02h", want.out_byte,
                         got.out_byte);
                  error_count++;
               end
               if (got.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                         got.last_of_run);
                  error_count++;
               end
               if (got.last_of_text !== want.last_of_text) begin
                  $error("last_of_text: expected %0b, got %0b", want.last_of_text,
                         got.last_of_text);
                  error_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            item = stimulus[taken_count];
            taken_count++;
            decode_step(item.in_byte, item.end_of_text);
            if (item.known) begin
               n = item.known_text.len();
               for (int k = 0; k < n; k++)
                  pending_results.push_back('{item.known_text[k], (k == n - 1),
                                              (k == n - 1) && item.end_of_text});
            end else begin
               foreach (step_bytes[k]) pending_results.push_back(step_bytes[k]);
            end
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_if.ready <= 1'b0;
            for (int c = 0; c < HoldOffCycles; c++) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (stall_left > 0 && !quiet_phase) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = 0;
            if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // run watchdog
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // reset, then send every item
   initial begin
      int gap;
      int first_random;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.in_byte <= 8'h00;
      req_if.end_of_text <= 1'b0;
      held_len = '0;
      live_set = '0;
      taken_count = 0;
      error_count = 0;
      hold_off_req = 1'b0;
      quiet_phase = 1'b0;
      foreach (directed_rows[i]) stimulus.push_back(directed_rows[i]);
      first_random = stimulus.size();
      build_random();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int idx = 0; idx < stimulus.size(); idx++) begin
         // pause until the block has drained
         if (idx == first_random || idx == first_random + 120) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (idx == first_random + 50) hold_off_req = 1'b1;
         quiet_phase = (idx >= first_random + 70) && (idx < first_random + 110);
         gap = quiet_phase ? 0 : pick_gap();
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.in_byte <= stimulus[idx].in_byte;
         req_if.end_of_text <= stimulus[idx].end_of_text;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
      end
      req_if.valid <= 1'b0;
      quiet_phase = 1'b0;

      // wait for the last results and a further drain period, then report
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
